// ----- hw/rtl/mgs_pkg.sv -----
// ============================================================================
// mgs_pkg
// Shared types and constants of the motion gesture segmenter: input kinds,
// phase codes, configuration register indexes and the structs that travel
// between the pipeline stages.
// ============================================================================
package mgs_pkg;

    // Fixed field widths
    localparam int LEVEL_W   = 34;
    localparam int HOLD_W    = 16;
    localparam int TARGET_W  = 8;
    localparam int CAPTURE_W = TARGET_W + 1;
    localparam int LENGTH_W  = 16;
    localparam int KIND_W    = 2;
    localparam int PHASE_W   = 3;
    localparam int CFG_IDX_W = 3;

    // Reset values of the configuration registers
    localparam logic [LEVEL_W-1:0] START_LEVEL_RST = LEVEL_W'(268435456);
    localparam logic [HOLD_W-1:0]  START_HOLD_RST  = HOLD_W'(100);
    localparam logic [LEVEL_W-1:0] STOP_LEVEL_RST  = LEVEL_W'(268435456);
    localparam logic [HOLD_W-1:0]  STOP_HOLD_RST   = HOLD_W'(200);

    // Largest reported capture length
    localparam logic [LENGTH_W-1:0] LENGTH_MAX = {LENGTH_W{1'b1}};

    // Kind of an input item
    typedef enum logic [KIND_W-1:0] {
        KIND_SAMPLE  = 2'd0,
        KIND_TICK    = 2'd1,
        KIND_REQUEST = 2'd2
    } kind_t;

    // Phase codes
    typedef enum logic [PHASE_W-1:0] {
        PH_IDLE         = 3'd0,
        PH_ARMED        = 3'd1,
        PH_CAPTURING    = 3'd2,
        PH_RECOGNIZING  = 3'd3,
        PH_CAPTURE_DONE = 3'd4,
        PH_RECOGNIZED   = 3'd5
    } phase_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_LEVEL = 3'd0,
        CFG_START_HOLD  = 3'd1,
        CFG_STOP_LEVEL  = 3'd2,
        CFG_STOP_HOLD   = 3'd3
    } cfg_idx_t;

    // Configuration register set
    typedef struct packed {
        logic [LEVEL_W-1:0] start_level_sq;
        logic [HOLD_W-1:0]  start_hold_ms;
        logic [LEVEL_W-1:0] stop_level_sq;
        logic [HOLD_W-1:0]  stop_hold_ms;
    } cfg_t;

    // Control part of an item, carried beside the sample path
    typedef struct packed {
        kind_t                kind;
        logic [CAPTURE_W-1:0] capture_target;
    } ctl_t;

    // One result item
    typedef struct packed {
        logic [LENGTH_W-1:0] capture_length_ms;
        logic [TARGET_W-1:0] training_target;
        logic                ended_as_training;
        logic                segment_ended;
        logic                segment_started;
        logic                sample_in_segment;
        phase_t              phase_code;
    } res_t;

endpackage

// ----- hw/rtl/mgs_magnitude.sv -----
// ============================================================================
// mgs_magnitude
// Two-stage squared magnitude pipe: squares of the three axes, then their sum.
// Control fields ride along; each stage holds under backpressure.
// ============================================================================
module mgs_magnitude #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  mgs_pkg::ctl_t                in_ctl,
    input  logic signed [SAMPLE_BITS-1:0] in_x,
    input  logic signed [SAMPLE_BITS-1:0] in_y,
    input  logic signed [SAMPLE_BITS-1:0] in_z,
    output logic                         out_valid,
    input  logic                         out_ready,
    output mgs_pkg::ctl_t                out_ctl,
    output logic [2*SAMPLE_BITS+1:0]     out_mag
);

    localparam int SQ_BITS  = 2 * SAMPLE_BITS;
    localparam int MAG_BITS = SQ_BITS + 2;

    logic                      sq_valid_reg;
    mgs_pkg::ctl_t             sq_ctl_reg;
    logic [SQ_BITS-1:0]        sq_x_reg;
    logic [SQ_BITS-1:0]        sq_y_reg;
    logic [SQ_BITS-1:0]        sq_z_reg;
    logic                      sum_valid_reg;
    mgs_pkg::ctl_t             sum_ctl_reg;
    logic [MAG_BITS-1:0]       sum_mag_reg;
    logic                      sq_ready;
    logic                      sum_ready;
    logic signed [SQ_BITS-1:0] prod_x;
    logic signed [SQ_BITS-1:0] prod_y;
    logic signed [SQ_BITS-1:0] prod_z;

    // Stage readiness: a stage takes data when empty or draining
    assign sum_ready = !sum_valid_reg || out_ready;
    assign sq_ready  = !sq_valid_reg || sum_ready;
    assign in_ready  = sq_ready;

    // Square each axis
    assign prod_x = in_x * in_x;
    assign prod_y = in_y * in_y;
    assign prod_z = in_z * in_z;

    // Square stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_valid_reg <= 1'b0;
        end
        else if (sq_ready)
        begin
            sq_valid_reg <= in_valid;
        end
    end

    // Square stage payload
    always_ff @(posedge clk)
    begin
        if (sq_ready && in_valid)
        begin
            sq_ctl_reg <= in_ctl;
            sq_x_reg   <= $unsigned(prod_x);
            sq_y_reg   <= $unsigned(prod_y);
            sq_z_reg   <= $unsigned(prod_z);
        end
    end

    // Sum stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_valid_reg <= 1'b0;
        end
        else if (sum_ready)
        begin
            sum_valid_reg <= sq_valid_reg;
        end
    end

    // Sum stage payload
    always_ff @(posedge clk)
    begin
        if (sum_ready && sq_valid_reg)
        begin
            sum_ctl_reg <= sq_ctl_reg;
            sum_mag_reg <= MAG_BITS'(sq_x_reg) + MAG_BITS'(sq_y_reg) + MAG_BITS'(sq_z_reg);
        end
    end

    assign out_valid = sum_valid_reg;
    assign out_ctl   = sum_ctl_reg;
    assign out_mag   = sum_mag_reg;

endmodule

// ----- hw/rtl/mgs_segmenter.sv -----
// ============================================================================
// mgs_segmenter
// Segment and capture state update with the result register. Compares the
// squared magnitude with the start and stop levels, runs the hold and length
// timers, and loads one result per sample or capture request.
// ============================================================================
module mgs_segmenter #(
    parameter int TIMER_BITS = 16,
    parameter int MAG_BITS   = 34
) (
    input  logic                clk,
    input  logic                rst_n,
    input  mgs_pkg::cfg_t       cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  mgs_pkg::ctl_t       in_ctl,
    input  logic [MAG_BITS-1:0] in_mag,
    output logic                out_valid,
    input  logic                out_ready,
    output mgs_pkg::res_t       out_res
);

    localparam int CMP_BITS = (MAG_BITS > mgs_pkg::LEVEL_W) ? MAG_BITS : mgs_pkg::LEVEL_W;
    localparam int CNT_BITS = (TIMER_BITS > mgs_pkg::LENGTH_W) ? TIMER_BITS
                                                                : mgs_pkg::LENGTH_W;
    localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

    // State registers
    logic                          segment_active_reg;
    logic                          segment_active_next;
    logic                          capture_armed_reg;
    logic                          capture_armed_next;
    logic [mgs_pkg::TARGET_W-1:0]  armed_target_reg;
    logic [mgs_pkg::TARGET_W-1:0]  armed_target_next;
    mgs_pkg::phase_t               phase_reg;
    mgs_pkg::phase_t               phase_next;
    logic [TIMER_BITS-1:0]         hold_ticks_reg;
    logic [TIMER_BITS-1:0]         hold_ticks_next;
    logic [TIMER_BITS-1:0]         length_ticks_reg;
    logic [TIMER_BITS-1:0]         length_ticks_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    mgs_pkg::res_t                 res_reg;
    mgs_pkg::res_t                 res_next;

    // Decisions
    logic accept;
    logic is_sample;
    logic is_request;
    logic mag_above;
    logic mag_below;
    logic start_hold_met;
    logic stop_hold_met;
    logic start_fire;
    logic end_fire;
    logic cancel;
    logic [TIMER_BITS-1:0]         hold_inc;
    logic [TIMER_BITS-1:0]         length_inc;
    logic [mgs_pkg::LENGTH_W-1:0]  length_sat;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // Compare magnitude and timers
    always_comb
    begin
        is_sample      = (in_ctl.kind == mgs_pkg::KIND_SAMPLE);
        is_request     = (in_ctl.kind == mgs_pkg::KIND_REQUEST);
        cancel         = in_ctl.capture_target[mgs_pkg::CAPTURE_W-1];
        mag_above      = CMP_BITS'(in_mag) > CMP_BITS'(cfg.start_level_sq);
        mag_below      = CMP_BITS'(in_mag) < CMP_BITS'(cfg.stop_level_sq);
        start_hold_met = CNT_BITS'(hold_ticks_reg) >= CNT_BITS'(cfg.start_hold_ms);
        stop_hold_met  = CNT_BITS'(hold_ticks_reg) >= CNT_BITS'(cfg.stop_hold_ms);
        start_fire     = is_sample && !segment_active_reg && mag_above && start_hold_met;
        end_fire       = is_sample && segment_active_reg && mag_below && stop_hold_met;
        hold_inc       = (hold_ticks_reg == TIMER_MAX) ? TIMER_MAX : hold_ticks_reg + 1'b1;
        length_inc     = (length_ticks_reg == TIMER_MAX) ? TIMER_MAX
                                                         : length_ticks_reg + 1'b1;
        if (CNT_BITS'(length_ticks_reg) > CNT_BITS'(mgs_pkg::LENGTH_MAX))
        begin
            length_sat = mgs_pkg::LENGTH_MAX;
        end
        else
        begin
            length_sat = mgs_pkg::LENGTH_W'(CNT_BITS'(length_ticks_reg));
        end
    end

    // Next state
    always_comb
    begin
        segment_active_next = segment_active_reg;
        capture_armed_next  = capture_armed_reg;
        armed_target_next   = armed_target_reg;
        phase_next          = phase_reg;
        hold_ticks_next     = hold_ticks_reg;
        length_ticks_next   = length_ticks_reg;
        case (in_ctl.kind)
            mgs_pkg::KIND_TICK:
            begin
                hold_ticks_next   = hold_inc;
                length_ticks_next = length_inc;
            end
            mgs_pkg::KIND_REQUEST:
            begin
                hold_ticks_next = '0;
                if (!capture_armed_reg && !cancel)
                begin
                    capture_armed_next = 1'b1;
                    armed_target_next  = in_ctl.capture_target[mgs_pkg::TARGET_W-1:0];
                    phase_next         = mgs_pkg::PH_ARMED;
                end
                else
                begin
                    capture_armed_next = 1'b0;
                    phase_next         = mgs_pkg::PH_IDLE;
                end
            end
            mgs_pkg::KIND_SAMPLE:
            begin
                if (segment_active_reg)
                begin
                    phase_next = capture_armed_reg ? mgs_pkg::PH_CAPTURING
                                                   : mgs_pkg::PH_RECOGNIZING;
                    if (!mag_below)
                    begin
                        hold_ticks_next = '0;
                    end
                    else if (stop_hold_met)
                    begin
                        phase_next = capture_armed_reg ? mgs_pkg::PH_CAPTURE_DONE
                                                       : mgs_pkg::PH_RECOGNIZED;
                        capture_armed_next  = 1'b0;
                        segment_active_next = 1'b0;
                        hold_ticks_next     = '0;
                    end
                end
                else
                begin
                    if (!mag_above)
                    begin
                        hold_ticks_next = '0;
                        phase_next = capture_armed_reg ? mgs_pkg::PH_ARMED
                                                       : mgs_pkg::PH_IDLE;
                    end
                    else if (start_hold_met)
                    begin
                        segment_active_next = 1'b1;
                        hold_ticks_next     = '0;
                        if (capture_armed_reg)
                        begin
                            length_ticks_next = '0;
                        end
                    end
                end
            end
            default:
            begin
                // unused kind: leave state alone
            end
        endcase
    end

    // Result fields and output valid
    always_comb
    begin
        res_next.phase_code        = phase_next;
        res_next.sample_in_segment = is_sample && segment_active_reg;
        res_next.segment_started   = start_fire;
        res_next.segment_ended     = end_fire;
        res_next.ended_as_training = end_fire && capture_armed_reg;
        res_next.training_target   = (end_fire && capture_armed_reg) ? armed_target_reg : '0;
        res_next.capture_length_ms = (end_fire && capture_armed_reg) ? length_sat : '0;
        if (accept)
        begin
            out_valid_next = is_sample || is_request;
        end
        else
        begin
            out_valid_next = out_valid_reg && !out_ready;
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            segment_active_reg <= 1'b0;
            capture_armed_reg  <= 1'b0;
            armed_target_reg   <= '0;
            phase_reg          <= mgs_pkg::PH_IDLE;
            hold_ticks_reg     <= '0;
            length_ticks_reg   <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                segment_active_reg <= segment_active_next;
                capture_armed_reg  <= capture_armed_next;
                armed_target_reg   <= armed_target_next;
                phase_reg          <= phase_next;
                hold_ticks_reg     <= hold_ticks_next;
                length_ticks_reg   <= length_ticks_next;
            end
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (accept && (is_sample || is_request))
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = res_reg;

    // A held result always matches the state left by its own item
    a_phase_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (res_reg.phase_code == phase_reg))
        else $error("result phase differs from phase state");

    a_started_active: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.segment_started) |-> segment_active_reg)
        else $error("segment start reported but segment not active");

    a_ended_inactive: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.segment_ended) |-> (!segment_active_reg && !capture_armed_reg))
        else $error("segment end reported but segment or capture still running");

    a_training_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.ended_as_training) |->
        (res_reg.segment_ended && (phase_reg == mgs_pkg::PH_CAPTURE_DONE)))
        else $error("training end without capture done phase");

    a_ended_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && end_fire) |=> (out_valid_reg && res_reg.segment_ended))
        else $error("segment end lost");

endmodule

// ----- hw/rtl/motion_gesture_segmenter_top.sv -----
// ============================================================================
// motion_gesture_segmenter_top
// Splits a 3-axis accelerometer stream into gesture segments with start and
// stop levels on the squared magnitude and millisecond hold times, and tracks
// training capture requests.
//
//  channel  | direction | handshake            | content
//  ---------+-----------+----------------------+------------------------------
//  s_axis   | in        | s_tvalid / s_tready  | sample, tick or capture request
//  m_axis   | out       | m_tvalid / m_tready  | one result per sample/request
//  cfg      | in        | cfg_valid / cfg_ready| register index and value
//
// Throughput is one item per cycle while m_axis does not stall; a result appears on m_axis
// once its item has passed the input register, squares, sum and state update.
// Ticks pass through the pipe and update the timers without a result; unused
// kinds pass through and are dropped.
// Backpressure on m_axis stalls only as far as stages are full; bubbles collapse.
// Reset clears the valid flags and segment state and loads the configuration
// defaults; cfg_ready is always high and writes take effect at once.
// ============================================================================
module motion_gesture_segmenter_top #(
    parameter int SAMPLE_BITS = 16,
    parameter int TIMER_BITS  = 16
) (
    input  logic clk,
    input  logic rst_n,

    // s_tdata fields, low to high: accel_x, accel_y, accel_z, capture_target
    input  logic [((3*SAMPLE_BITS+mgs_pkg::CAPTURE_W+7)/8)*8-1:0] s_tdata,
    // s_tuser fields: kind
    input  logic [mgs_pkg::KIND_W-1:0]                            s_tuser,
    input  logic                                                  s_tvalid,
    output logic                                                  s_tready,

    // m_tdata fields, low to high: phase_code, sample_in_segment,
    // segment_started, segment_ended, ended_as_training, training_target,
    // capture_length_ms
    output logic [31:0]                                           m_tdata,
    output logic                                                  m_tvalid,
    input  logic                                                  m_tready,

    input  logic                                                  cfg_valid,
    output logic                                                  cfg_ready,
    input  logic [mgs_pkg::CFG_IDX_W-1:0]                         cfg_index,
    input  logic [mgs_pkg::LEVEL_W-1:0]                           cfg_data
);

    localparam int MAG_BITS = 2 * SAMPLE_BITS + 2;
    localparam int TGT_LSB  = 3 * SAMPLE_BITS;

    mgs_pkg::cfg_t                 cfg_reg;
    logic                          in_valid_reg;
    mgs_pkg::ctl_t                 in_ctl_reg;
    logic signed [SAMPLE_BITS-1:0] in_x_reg;
    logic signed [SAMPLE_BITS-1:0] in_y_reg;
    logic signed [SAMPLE_BITS-1:0] in_z_reg;
    logic                          mag_in_ready;
    logic                          mag_valid;
    logic                          seg_ready;
    mgs_pkg::ctl_t                 mag_ctl;
    logic [MAG_BITS-1:0]           mag_value;
    mgs_pkg::res_t                 res;
    logic                          in_take;

    // Configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_level_sq <= mgs_pkg::START_LEVEL_RST;
            cfg_reg.start_hold_ms  <= mgs_pkg::START_HOLD_RST;
            cfg_reg.stop_level_sq  <= mgs_pkg::STOP_LEVEL_RST;
            cfg_reg.stop_hold_ms   <= mgs_pkg::STOP_HOLD_RST;
        end
        else if (cfg_valid)
        begin
            case (mgs_pkg::cfg_idx_t'(cfg_index))
                mgs_pkg::CFG_START_LEVEL: cfg_reg.start_level_sq <= cfg_data;
                mgs_pkg::CFG_START_HOLD:  cfg_reg.start_hold_ms  <= cfg_data[mgs_pkg::HOLD_W-1:0];
                mgs_pkg::CFG_STOP_LEVEL:  cfg_reg.stop_level_sq  <= cfg_data;
                mgs_pkg::CFG_STOP_HOLD:   cfg_reg.stop_hold_ms   <= cfg_data[mgs_pkg::HOLD_W-1:0];
                default:
                begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    // Input register
    assign s_tready = !in_valid_reg || mag_in_ready;
    assign in_take  = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_ctl_reg.kind           <= mgs_pkg::kind_t'(s_tuser);
            in_ctl_reg.capture_target <= s_tdata[TGT_LSB +: mgs_pkg::CAPTURE_W];
            in_x_reg                  <= s_tdata[0 +: SAMPLE_BITS];
            in_y_reg                  <= s_tdata[SAMPLE_BITS +: SAMPLE_BITS];
            in_z_reg                  <= s_tdata[2*SAMPLE_BITS +: SAMPLE_BITS];
        end
    end

    // Squared magnitude pipe
    mgs_magnitude #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_magnitude (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid_reg),
        .in_ready  (mag_in_ready),
        .in_ctl    (in_ctl_reg),
        .in_x      (in_x_reg),
        .in_y      (in_y_reg),
        .in_z      (in_z_reg),
        .out_valid (mag_valid),
        .out_ready (seg_ready),
        .out_ctl   (mag_ctl),
        .out_mag   (mag_value)
    );

    // Segment state and result register
    mgs_segmenter #(
        .TIMER_BITS (TIMER_BITS),
        .MAG_BITS   (MAG_BITS)
    ) u_segmenter (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (mag_valid),
        .in_ready  (seg_ready),
        .in_ctl    (mag_ctl),
        .in_mag    (mag_value),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    // Pack the result
    assign m_tdata = {1'b0,
                      res.capture_length_ms,
                      res.training_target,
                      res.ended_as_training,
                      res.segment_ended,
                      res.segment_started,
                      res.sample_in_segment,
                      res.phase_code};

endmodule
